@@ sv/affine_rect_bounding_box_unit_macros.svh @@
// assertion helpers for the checker file
`ifndef AFFINE_RECT_BOUNDING_BOX_UNIT_MACROS_SVH
`define AFFINE_RECT_BOUNDING_BOX_UNIT_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define ARBB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arbb check failed");

// next-cycle implication, clocked on clock, off during reset
`define ARBB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arbb check failed");

`endif

@@ sv/arbb_pkg.sv @@
`timescale 1ns / 1ps

package arbb_pkg;

   localparam int PIX_W       = 16;
   localparam int COORD_W     = 18;   // left + width needs two more bits
   localparam int COEF_W      = 32;   // Q8.24
   localparam int OFF_W       = 32;   // Q16.16
   localparam int PROD_W      = COEF_W + COORD_W;
   localparam int OPROD_W     = COEF_W + OFF_W;
   localparam int CORNER_W    = 72;   // mapped coordinate, 40 fraction bits
   localparam int FRAC_W      = 40;
   localparam int MAG_W       = CORNER_W - FRAC_W;
   localparam int COORD_SHIFT = 16;
   localparam int TRANS_SHIFT = 24;
   localparam int BOX_W       = 24;
   localparam int CSR_W       = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_STAGES  = 7;

   localparam logic [CORNER_W-1:0] ROUND_HALF =
      {{(CORNER_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
   localparam logic [MAG_W-1:0] POS_LIM  = MAG_W'((64'd1 << (BOX_W-1)) - 64'd1);
   localparam logic [MAG_W-1:0] NEG_LIM  = MAG_W'(64'd1 << (BOX_W-1));
   localparam logic [MAG_W-1:0] SPAN_LIM = MAG_W'((64'd1 << BOX_W) - 64'd1);

   localparam logic [CSR_W-1:0] AB_RESET  = 64'h0000_0000_0100_0000;
   localparam logic [CSR_W-1:0] CD_RESET  = 64'h0100_0000_0000_0000;
   localparam logic [CSR_W-1:0] OFF_RESET = 64'h0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FWD_AB     = 3'd0,
      CSR_FWD_CD     = 3'd1,
      CSR_INV_AB     = 3'd2,
      CSR_INV_CD     = 3'd3,
      CSR_IN_OFFSET  = 3'd4,
      CSR_OUT_OFFSET = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_FORWARD = 1'b0,
      OP_INVERSE = 1'b1
   } opcode_type;

   // per-stage advance strobes handed to each axis datapath
   typedef struct packed {
      logic prod_en;
      logic term_en;
      logic cmp_en;
      logic sum_en;
      logic mag_en;
      logic out_en;
   } arbb_ctl_type;

endpackage

@@ sv/arbb_axis.sv @@
`timescale 1ns / 1ps

module arbb_axis
   import arbb_pkg::*;
(
   input  logic                       clock,
   input  arbb_ctl_type               ctl,
   input  logic                       inv,
   input  logic signed [COEF_W-1:0]   coef_h,
   input  logic signed [COEF_W-1:0]   coef_v,
   input  logic signed [COORD_W-1:0]  h0,
   input  logic signed [COORD_W-1:0]  h1,
   input  logic signed [COORD_W-1:0]  v0,
   input  logic signed [COORD_W-1:0]  v1,
   input  logic signed [OFF_W-1:0]    off_h,
   input  logic signed [OFF_W-1:0]    off_v,
   input  logic signed [OFF_W-1:0]    t_off,
   output logic signed [BOX_W-1:0]    box_pos,
   output logic        [BOX_W-1:0]    box_span
);

   // products
   logic signed [PROD_W-1:0]   ph0_ff, ph1_ff, qv0_ff, qv1_ff;
   logic signed [OPROD_W-1:0]  po_ff, qo_ff;
   logic signed [OFF_W-1:0]    t2_ff;
   logic                       inv2_ff;

   // corner terms
   logic signed [CORNER_W-1:0] th0_in, th1_in, tv0_in, tv1_in, t3_in;
   logic signed [CORNER_W-1:0] th0_ff, th1_ff, tv0_ff, tv1_ff, t3_ff;

   // min and spread per term
   logic signed [CORNER_W-1:0] dh_in, dv_in, minh_in, minv_in;
   logic signed [CORNER_W-1:0] dh_ff, dv_ff, minh_ff, minv_ff, t4_ff;

   // box edge and span
   logic signed [CORNER_W-1:0] pos_in, span_in, ah, av;
   logic signed [CORNER_W-1:0] pos5_ff, span5_ff;

   // magnitude
   logic                       neg6_ff;
   logic        [CORNER_W-1:0] mag6_in, mag6_ff, span6_ff;

   // rounding
   logic        [CORNER_W-1:0] rpos, rspan;
   logic        [MAG_W-1:0]    mpos, mspan, mneg_clip, neg_full;
   logic signed [BOX_W-1:0]    box_pos_in, box_pos_ff;
   logic        [BOX_W-1:0]    box_span_in, box_span_ff;

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         ph0_ff  <= coef_h * h0;
         ph1_ff  <= coef_h * h1;
         qv0_ff  <= coef_v * v0;
         qv1_ff  <= coef_v * v1;
         po_ff   <= coef_h * off_h;
         qo_ff   <= coef_v * off_v;
         t2_ff   <= t_off;
         inv2_ff <= inv;
      end
   end

   // coef * (x << 16 +/- off) split into coef*x and coef*off
   always_comb begin
      logic signed [CORNER_W-1:0] sh0, sh1, sv0, sv1, epo, eqo, et;
      sh0 = CORNER_W'(ph0_ff) <<< COORD_SHIFT;
      sh1 = CORNER_W'(ph1_ff) <<< COORD_SHIFT;
      sv0 = CORNER_W'(qv0_ff) <<< COORD_SHIFT;
      sv1 = CORNER_W'(qv1_ff) <<< COORD_SHIFT;
      epo = CORNER_W'(po_ff);
      eqo = CORNER_W'(qo_ff);
      et  = CORNER_W'(t2_ff) <<< TRANS_SHIFT;
      if (inv2_ff) begin
         th0_in = sh0 - epo;
         th1_in = sh1 - epo;
         tv0_in = sv0 - eqo;
         tv1_in = sv1 - eqo;
         t3_in  = -et;
      end else begin
         th0_in = sh0 + epo;
         th1_in = sh1 + epo;
         tv0_in = sv0 + eqo;
         tv1_in = sv1 + eqo;
         t3_in  = et;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.term_en) begin
         th0_ff <= th0_in;
         th1_ff <= th1_in;
         tv0_ff <= tv0_in;
         tv1_ff <= tv1_in;
         t3_ff  <= t3_in;
      end
   end

   // corners are sums of one h term and one v term, so min/max separate
   always_comb begin
      dh_in   = th0_ff - th1_ff;
      dv_in   = tv0_ff - tv1_ff;
      minh_in = dh_in[CORNER_W-1] ? th0_ff : th1_ff;
      minv_in = dv_in[CORNER_W-1] ? tv0_ff : tv1_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         dh_ff   <= dh_in;
         dv_ff   <= dv_in;
         minh_ff <= minh_in;
         minv_ff <= minv_in;
         t4_ff   <= t3_ff;
      end
   end

   always_comb begin
      ah      = dh_ff[CORNER_W-1] ? -dh_ff : dh_ff;
      av      = dv_ff[CORNER_W-1] ? -dv_ff : dv_ff;
      pos_in  = minh_ff + minv_ff + t4_ff;
      span_in = ah + av;
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         pos5_ff  <= pos_in;
         span5_ff <= span_in;
      end
   end

   assign mag6_in = pos5_ff[CORNER_W-1] ? unsigned'(-pos5_ff) : unsigned'(pos5_ff);

   always_ff @(posedge clock) begin
      if (ctl.mag_en) begin
         neg6_ff  <= pos5_ff[CORNER_W-1];
         mag6_ff  <= mag6_in;
         span6_ff <= unsigned'(span5_ff);
      end
   end

   // round half away from zero on the magnitude, then clamp
   always_comb begin
      rpos      = mag6_ff + ROUND_HALF;
      rspan     = span6_ff + ROUND_HALF;
      mpos      = rpos[CORNER_W-1:FRAC_W];
      mspan     = rspan[CORNER_W-1:FRAC_W];
      mneg_clip = (mpos > NEG_LIM) ? NEG_LIM : mpos;
      neg_full  = MAG_W'(0) - mneg_clip;
      if (neg6_ff) begin
         box_pos_in = signed'(neg_full[BOX_W-1:0]);
      end else if (mpos > POS_LIM) begin
         box_pos_in = signed'(POS_LIM[BOX_W-1:0]);
      end else begin
         box_pos_in = signed'(mpos[BOX_W-1:0]);
      end
      box_span_in = (mspan > SPAN_LIM) ? SPAN_LIM[BOX_W-1:0] : mspan[BOX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.out_en) begin
         box_pos_ff  <= box_pos_in;
         box_span_ff <= box_span_in;
      end
   end

   assign box_pos  = box_pos_ff;
   assign box_span = box_span_ff;

endmodule

@@ sv/affine_rect_bounding_box_unit.sv @@
// channel   direction  handshake             beat
// req_      in         req_valid/req_stall   opcode, rect left/top/width/height
// rsp_      out        rsp_valid/rsp_stall   box left/top/width/height
// csr_      in         csr_wr_en             csr_index, csr_wdata (64 bits)
//
// one beat per cycle sustained while rsp_stall is low; a request passes
// through seven register stages to its response: capture, multiply, corner terms,
// min/spread, edge sum, magnitude, round/saturate.
// synchronous reset clears the pipe valid bits and loads the identity transform.
// a stalled response holds only the stages behind it that are full; empty
// stages keep taking request beats.
`timescale 1ns / 1ps

module affine_rect_bounding_box_unit
   import arbb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_opcode,
   input  logic signed [PIX_W-1:0]   req_rect_left,
   input  logic signed [PIX_W-1:0]   req_rect_top,
   input  logic        [PIX_W-1:0]   req_rect_width,
   input  logic        [PIX_W-1:0]   req_rect_height,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [BOX_W-1:0]   rsp_box_left,
   output logic signed [BOX_W-1:0]   rsp_box_top,
   output logic        [BOX_W-1:0]   rsp_box_width,
   output logic        [BOX_W-1:0]   rsp_box_height,

   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   logic [CSR_W-1:0] fwd_ab_ff, fwd_cd_ff, inv_ab_ff, inv_cd_ff;
   logic [CSR_W-1:0] in_offset_ff, out_offset_ff;

   logic [NUM_STAGES-1:0] vld_ff, en;
   arbb_ctl_type          ctl;

   logic                      inv1_ff;
   logic signed [COEF_W-1:0]  a1_ff, b1_ff, c1_ff, d1_ff;
   logic signed [COORD_W-1:0] left1_ff, right1_ff, top1_ff, bottom1_ff;
   logic signed [COORD_W-1:0] left_ext, top_ext;
   logic signed [OFF_W-1:0]   offx1_ff, offy1_ff, tx1_ff, ty1_ff;
   logic                      inv_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ab_ff     <= AB_RESET;
         fwd_cd_ff     <= CD_RESET;
         inv_ab_ff     <= AB_RESET;
         inv_cd_ff     <= CD_RESET;
         in_offset_ff  <= OFF_RESET;
         out_offset_ff <= OFF_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FWD_AB:     fwd_ab_ff     <= csr_wdata;
            CSR_FWD_CD:     fwd_cd_ff     <= csr_wdata;
            CSR_INV_AB:     inv_ab_ff     <= csr_wdata;
            CSR_INV_CD:     inv_cd_ff     <= csr_wdata;
            CSR_IN_OFFSET:  in_offset_ff  <= csr_wdata;
            CSR_OUT_OFFSET: out_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage advances when it is empty or the one after it advances
   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   assign ctl.prod_en = en[1];
   assign ctl.term_en = en[2];
   assign ctl.cmp_en  = en[3];
   assign ctl.sum_en  = en[4];
   assign ctl.mag_en  = en[5];
   assign ctl.out_en  = en[6];

   assign inv_sel  = (opcode_type'(req_opcode) == OP_INVERSE);
   assign left_ext = COORD_W'(req_rect_left);
   assign top_ext  = COORD_W'(req_rect_top);

   // capture stage: pick the matrix and the offset roles for the direction
   always_ff @(posedge clock) begin
      if (en[0]) begin
         inv1_ff    <= inv_sel;
         a1_ff      <= inv_sel ? inv_ab_ff[COEF_W-1:0]       : fwd_ab_ff[COEF_W-1:0];
         b1_ff      <= inv_sel ? inv_ab_ff[CSR_W-1:COEF_W]   : fwd_ab_ff[CSR_W-1:COEF_W];
         c1_ff      <= inv_sel ? inv_cd_ff[COEF_W-1:0]       : fwd_cd_ff[COEF_W-1:0];
         d1_ff      <= inv_sel ? inv_cd_ff[CSR_W-1:COEF_W]   : fwd_cd_ff[CSR_W-1:COEF_W];
         offx1_ff   <= inv_sel ? out_offset_ff[OFF_W-1:0]     : in_offset_ff[OFF_W-1:0];
         offy1_ff   <= inv_sel ? out_offset_ff[CSR_W-1:OFF_W] : in_offset_ff[CSR_W-1:OFF_W];
         tx1_ff     <= inv_sel ? in_offset_ff[OFF_W-1:0]      : out_offset_ff[OFF_W-1:0];
         ty1_ff     <= inv_sel ? in_offset_ff[CSR_W-1:OFF_W]  : out_offset_ff[CSR_W-1:OFF_W];
         left1_ff   <= left_ext;
         top1_ff    <= top_ext;
         right1_ff  <= left_ext + signed'(COORD_W'(req_rect_width));
         bottom1_ff <= top_ext + signed'(COORD_W'(req_rect_height));
      end
   end

   arbb_axis u_axis_x (
      .clock    (clock),
      .ctl      (ctl),
      .inv      (inv1_ff),
      .coef_h   (a1_ff),
      .coef_v   (b1_ff),
      .h0       (left1_ff),
      .h1       (right1_ff),
      .v0       (top1_ff),
      .v1       (bottom1_ff),
      .off_h    (offx1_ff),
      .off_v    (offy1_ff),
      .t_off    (tx1_ff),
      .box_pos  (rsp_box_left),
      .box_span (rsp_box_width)
   );

   arbb_axis u_axis_y (
      .clock    (clock),
      .ctl      (ctl),
      .inv      (inv1_ff),
      .coef_h   (c1_ff),
      .coef_v   (d1_ff),
      .h0       (left1_ff),
      .h1       (right1_ff),
      .v0       (top1_ff),
      .v1       (bottom1_ff),
      .off_h    (offx1_ff),
      .off_v    (offy1_ff),
      .t_off    (ty1_ff),
      .box_pos  (rsp_box_top),
      .box_span (rsp_box_height)
   );

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

endmodule

@@ sv/arbb_checker.sv @@
`timescale 1ns / 1ps
`include "affine_rect_bounding_box_unit_macros.svh"

module arbb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [23:0] rsp_box_left,
   input logic signed [23:0] rsp_box_top,
   input logic        [23:0] rsp_box_width,
   input logic        [23:0] rsp_box_height
);

   logic [95:0] rsp_beat;

   assign rsp_beat = {rsp_box_left, rsp_box_top, rsp_box_width, rsp_box_height};

   // a held response beat stays put
   `ARBB_ASSERT_NEXT(rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid)
   `ARBB_ASSERT_NEXT(rsp_hold_data, rsp_valid && rsp_stall, $stable(rsp_beat))

   // requests back up only behind a full, stalled pipe
   `ARBB_ASSERT_NOW(req_stall_cause, req_stall, rsp_valid && rsp_stall)

   // pipe comes out of reset empty
   `ARBB_ASSERT_NOW(rsp_empty_after_reset, $past(reset), !rsp_valid)

endmodule

bind affine_rect_bounding_box_unit arbb_checker u_arbb_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import arbb_pkg::*;

   localparam int NUM_CSR      = 6;
   localparam int RANDOM_ITEMS = 1000;
   localparam int NUM_PHASES   = 8;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = NUM_STAGES + 4;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      opcode_type                op;
      logic signed [PIX_W-1:0]   left;
      logic signed [PIX_W-1:0]   top;
      logic        [PIX_W-1:0]   width;
      logic        [PIX_W-1:0]   height;
   } rect_t;

   typedef struct packed {
      logic [BOX_W-1:0] left;
      logic [BOX_W-1:0] top;
      logic [BOX_W-1:0] width;
      logic [BOX_W-1:0] height;
   } box_t;

   typedef logic [CSR_W-1:0] csr_set_t [NUM_CSR];

   // ------------------------------------------------------------------
   class box_scoreboard;
      logic [CSR_W-1:0] regs [NUM_CSR];
      box_t             outstanding [$];
      int unsigned      requests;
      int unsigned      responses;
      int unsigned      mismatches;

      function new();
         regs[CSR_FWD_AB]     = AB_RESET;
         regs[CSR_FWD_CD]     = CD_RESET;
         regs[CSR_INV_AB]     = AB_RESET;
         regs[CSR_INV_CD]     = CD_RESET;
         regs[CSR_IN_OFFSET]  = OFF_RESET;
         regs[CSR_OUT_OFFSET] = OFF_RESET;
         requests   = 0;
         responses  = 0;
         mismatches = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
         if (idx < NUM_CSR)
            regs[idx] = data;
      endfunction

      function int unsigned pending();
         return outstanding.size();
      endfunction

      // corner mapped to a value with FRAC_W fraction bits
      function void map_corner(input logic inv, input logic signed [127:0] x,
                               input logic signed [127:0] y,
                               output logic signed [127:0] ox,
                               output logic signed [127:0] oy);
         logic [CSR_W-1:0]    ab, cd;
         logic signed [127:0] a, b, c, d, idx, idy, odx, ody, px, py, tx, ty;
         ab  = inv ? regs[CSR_INV_AB] : regs[CSR_FWD_AB];
         cd  = inv ? regs[CSR_INV_CD] : regs[CSR_FWD_CD];
         a   = $signed(ab[31:0]);
         b   = $signed(ab[63:32]);
         c   = $signed(cd[31:0]);
         d   = $signed(cd[63:32]);
         idx = $signed(regs[CSR_IN_OFFSET][31:0]);
         idy = $signed(regs[CSR_IN_OFFSET][63:32]);
         odx = $signed(regs[CSR_OUT_OFFSET][31:0]);
         ody = $signed(regs[CSR_OUT_OFFSET][63:32]);
         if (inv) begin
            px = (x <<< COORD_SHIFT) - odx;
            py = (y <<< COORD_SHIFT) - ody;
            tx = -(idx <<< TRANS_SHIFT);
            ty = -(idy <<< TRANS_SHIFT);
         end else begin
            px = (x <<< COORD_SHIFT) + idx;
            py = (y <<< COORD_SHIFT) + idy;
            tx = odx <<< TRANS_SHIFT;
            ty = ody <<< TRANS_SHIFT;
         end
         ox = a * px + b * py + tx;
         oy = c * px + d * py + ty;
      endfunction

      // round half away from zero, then clamp to the signed edge range
      function logic [BOX_W-1:0] round_edge(input logic signed [127:0] v);
         logic [127:0] m;
         logic         neg;
         neg = v[127];
         m   = neg ? -v : v;
         m   = (m + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
         if (!neg)
            return (m > POS_LIM) ? POS_LIM[BOX_W-1:0] : m[BOX_W-1:0];
         if (m > NEG_LIM)
            m = NEG_LIM;
         m = -m;
         return m[BOX_W-1:0];
      endfunction

      function logic [BOX_W-1:0] round_span(input logic signed [127:0] v);
         logic [127:0] m;
         if (v[127])
            return '0;
         m = (v + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
         return (m > SPAN_LIM) ? SPAN_LIM[BOX_W-1:0] : m[BOX_W-1:0];
      endfunction

      function box_t bound_rect(input rect_t r);
         logic signed [127:0] x0, x1, y0, y1, mx, my;
         logic signed [127:0] xmin, xmax, ymin, ymax;
         box_t                bx;
         x0 = $signed(r.left);
         y0 = $signed(r.top);
         x1 = x0 + $signed({1'b0, r.width});
         y1 = y0 + $signed({1'b0, r.height});
         for (int i = 0; i < 4; i++) begin
            map_corner(r.op == OP_INVERSE, i[0] ? x1 : x0, i[1] ? y1 : y0, mx, my);
            if (i == 0 || mx < xmin) xmin = mx;
            if (i == 0 || mx > xmax) xmax = mx;
            if (i == 0 || my < ymin) ymin = my;
            if (i == 0 || my > ymax) ymax = my;
         end
         bx.left   = round_edge(xmin);
         bx.top    = round_edge(ymin);
         bx.width  = round_span(xmax - xmin);
         bx.height = round_span(ymax - ymin);
         return bx;
      endfunction

      function void note_request(input rect_t r);
         requests++;
         outstanding.push_back(bound_rect(r));
      endfunction

      function void check_response(input box_t got);
         box_t want;
         responses++;
         if (outstanding.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected box beat: left %0d top %0d width %0d height %0d",
                        $signed(got.left), $signed(got.top), got.width, got.height);
            return;
         end
         want = outstanding.pop_front();
         if (got.left !== want.left || got.top !== want.top ||
             got.width !== want.width || got.height !== want.height) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("box %0d: expected l %0d t %0d w %0d h %0d, got l %0d t %0d w %0d h %0d",
                        responses, $signed(want.left), $signed(want.top), want.width,
                        want.height, $signed(got.left), $signed(got.top), got.width,
                        got.height);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   logic                    clock;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_stall;
   logic                    req_opcode      = 1'b0;
   logic signed [PIX_W-1:0] req_rect_left   = '0;
   logic signed [PIX_W-1:0] req_rect_top    = '0;
   logic        [PIX_W-1:0] req_rect_width  = '0;
   logic        [PIX_W-1:0] req_rect_height = '0;
   logic                    rsp_valid;
   logic                    rsp_stall       = 1'b0;
   logic signed [BOX_W-1:0] rsp_box_left;
   logic signed [BOX_W-1:0] rsp_box_top;
   logic        [BOX_W-1:0] rsp_box_width;
   logic        [BOX_W-1:0] rsp_box_height;
   logic                    csr_wr_en       = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index       = '0;
   logic [CSR_W-1:0]        csr_wdata       = '0;

   box_scoreboard sb = new();
   int unsigned   cycles     = 0;
   int unsigned   settings   = 1;
   bit            steady     = 1'b0;
   int            stall_left = 0;
   int            open_left  = 0;

   affine_rect_bounding_box_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_box_left    (rsp_box_left),
      .rsp_box_top     (rsp_box_top),
      .rsp_box_width   (rsp_box_width),
      .rsp_box_height  (rsp_box_height),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int stall_cycles();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic logic [PIX_W-1:0] pick_extreme16();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return 16'h0001;
      endcase
   endfunction

   function automatic logic [31:0] pick_extreme32();
      case ($urandom_range(0, 4))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return 32'h0100_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_coef(input int mode);
      int v;
      case (mode)
         0:       v = int'($urandom_range(0, 67108864)) - 33554432;  // within +-2.0
         1:       v = $urandom;
         2:       v = pick_extreme32();
         default: v = (int'($urandom_range(0, 8)) - 4) * 8388608;  // steps of one half
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_offset(input int mode);
      int v;
      case (mode)
         0:       v = int'($urandom_range(0, 4194304)) - 2097152;  // within +-32 pixels
         1:       v = $urandom;
         2:       v = pick_extreme32();
         default: v = (int'($urandom_range(0, 64)) - 32) * 32768;
      endcase
      return v;
   endfunction

   function automatic csr_set_t make_set(input int mode);
      csr_set_t s;
      s[CSR_FWD_AB]     = {pick_coef(mode), pick_coef(mode)};
      s[CSR_FWD_CD]     = {pick_coef(mode), pick_coef(mode)};
      s[CSR_INV_AB]     = {pick_coef(mode), pick_coef(mode)};
      s[CSR_INV_CD]     = {pick_coef(mode), pick_coef(mode)};
      s[CSR_IN_OFFSET]  = {pick_offset(mode), pick_offset(mode)};
      s[CSR_OUT_OFFSET] = {pick_offset(mode), pick_offset(mode)};
      return s;
   endfunction

   function automatic rect_t make_rect(input opcode_type op, input logic [PIX_W-1:0] l,
                                       input logic [PIX_W-1:0] t, input logic [PIX_W-1:0] w,
                                       input logic [PIX_W-1:0] h);
      return '{op: op, left: l, top: t, width: w, height: h};
   endfunction

   function automatic rect_t random_rect();
      rect_t r;
      r.op = opcode_type'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: begin
            r.left   = PIX_W'($urandom);
            r.top    = PIX_W'($urandom);
            r.width  = PIX_W'($urandom);
            r.height = PIX_W'($urandom);
         end
         1: begin  // small boxes near the origin, often degenerate
            r.left   = PIX_W'($urandom_range(0, 512) - 256);
            r.top    = PIX_W'($urandom_range(0, 512) - 256);
            r.width  = PIX_W'($urandom_range(0, 40));
            r.height = PIX_W'($urandom_range(0, 40));
         end
         2: begin
            r.left   = pick_extreme16();
            r.top    = pick_extreme16();
            r.width  = pick_extreme16();
            r.height = pick_extreme16();
         end
         default: begin
            r.left   = PIX_W'($urandom_range(0, 16383) - 8192);
            r.top    = PIX_W'($urandom_range(0, 16383) - 8192);
            r.width  = PIX_W'($urandom_range(0, 4095));
            r.height = PIX_W'($urandom_range(0, 4095));
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // all driving tasks start and end on a rising edge
   task automatic send_rect(input rect_t r);
      int gap;
      gap = steady ? 0 : gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= r.op;
      req_rect_left   <= r.left;
      req_rect_top    <= r.top;
      req_rect_width  <= r.width;
      req_rect_height <= r.height;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_csrs(input csr_set_t s, input bit stray);
      for (int i = 0; i < NUM_CSR; i++)
         csr_write(CSR_IDX_W'(i), s[i]);
      // indexes past the register list must be dropped
      if (stray) begin
         csr_write(CSR_IDX_W'(NUM_CSR), {$urandom, $urandom});
         csr_write(CSR_IDX_W'(NUM_CSR + 1), {$urandom, $urandom});
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && csr_wr_en)
         sb.write_reg(csr_index, csr_wdata);
      if (!reset && req_valid && !req_stall)
         sb.note_request({req_opcode, req_rect_left, req_rect_top, req_rect_width,
                          req_rect_height});
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_box_left, rsp_box_top, rsp_box_width, rsp_box_height});
   end

   // response back-pressure: short stalls, a few long ones, and open stretches
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (open_left > 0)
            open_left--;
         else if ($urandom_range(0, 99) < 4)
            open_left = $urandom_range(30, 300);
         else if ($urandom_range(0, 99) < 25)
            stall_left = stall_cycles();
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d boxes outstanding", cycles, sb.pending());
         $display("[affine_rect_bounding_box_unit] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   initial begin
      csr_set_t cfg;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // identity transform out of reset: field extremes, both directions
      send_rect(make_rect(OP_FORWARD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_rect(make_rect(OP_INVERSE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_rect(make_rect(OP_FORWARD, 16'h8000, 16'h8000, 16'hffff, 16'hffff));
      send_rect(make_rect(OP_INVERSE, 16'h8000, 16'h8000, 16'hffff, 16'hffff));
      send_rect(make_rect(OP_FORWARD, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff));
      send_rect(make_rect(OP_INVERSE, 16'h7fff, 16'h8000, 16'h0000, 16'hffff));
      send_rect(make_rect(OP_INVERSE, 16'hffff, 16'hffff, 16'h0001, 16'h0001));
      send_rect(make_rect(OP_FORWARD, 16'd100, 16'hffce, 16'h0000, 16'd7));
      send_rect(make_rect(OP_FORWARD, 16'h8000, 16'h7fff, 16'hffff, 16'h0000));
      req_valid <= 1'b0;
      settle();

      // half-pixel scale and offsets give exact halves; inverse swaps axes
      cfg[CSR_FWD_AB]     = {32'h0000_0000, 32'h0080_0000};
      cfg[CSR_FWD_CD]     = {32'hff80_0000, 32'h0000_0000};
      cfg[CSR_INV_AB]     = {32'h0100_0000, 32'h0000_0000};
      cfg[CSR_INV_CD]     = {32'h0000_0000, 32'h0100_0000};
      cfg[CSR_IN_OFFSET]  = {32'hffff_8000, 32'h0000_8000};
      cfg[CSR_OUT_OFFSET] = {32'h0001_8000, 32'hfffe_8000};
      program_csrs(cfg, 1'b1);
      settings++;
      send_rect(make_rect(OP_FORWARD, 16'd1, 16'd3, 16'd1, 16'd1));
      send_rect(make_rect(OP_FORWARD, 16'hfffd, 16'hffff, 16'd2, 16'd5));
      send_rect(make_rect(OP_INVERSE, 16'd5, 16'hfff9, 16'd3, 16'd0));
      send_rect(make_rect(OP_INVERSE, 16'h8000, 16'h7fff, 16'hffff, 16'hffff));
      req_valid <= 1'b0;
      settle();

      // largest coefficients and offsets saturate; zero inverse is singular
      cfg[CSR_FWD_AB]     = {32'h7fff_ffff, 32'h7fff_ffff};
      cfg[CSR_FWD_CD]     = {32'h8000_0000, 32'h8000_0000};
      cfg[CSR_INV_AB]     = '0;
      cfg[CSR_INV_CD]     = '0;
      cfg[CSR_IN_OFFSET]  = {32'h8000_0000, 32'h7fff_ffff};
      cfg[CSR_OUT_OFFSET] = {32'h7fff_ffff, 32'h8000_0000};
      program_csrs(cfg, 1'b0);
      settings++;
      send_rect(make_rect(OP_FORWARD, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff));
      send_rect(make_rect(OP_FORWARD, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
      send_rect(make_rect(OP_INVERSE, 16'h8000, 16'h7fff, 16'hffff, 16'h0000));
      send_rect(make_rect(OP_INVERSE, 16'h0000, 16'h0000, 16'hffff, 16'hffff));
      req_valid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         program_csrs(make_set(p % 4), 1'b0);
         settings++;
         for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++) begin
            if (i % 40 == 0)
               steady = ($urandom_range(0, 3) == 0);
            send_rect(random_rect());
         end
         req_valid <= 1'b0;
      end
      settle();

      $display("mapped %0d rectangles forward and inverse under %0d transform settings",
               sb.requests, settings);
      $display("checked %0d boxes, %0d mismatched, %0d never returned",
               sb.responses, sb.mismatches, sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[affine_rect_bounding_box_unit] OK");
      else
         $display("[affine_rect_bounding_box_unit] ERROR");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/arbb_pkg.sv
sv/arbb_axis.sv
sv/affine_rect_bounding_box_unit.sv
sv/arbb_checker.sv
tb/testbench.sv
